// File: src/itpd_pkg.sv
// Shared types and constants of the IR timing pair decoder.
package itpd_pkg;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_BYTE  = 2'd2;

	localparam int TABLE_DEPTH = 32;
	localparam int TABLE_AW    = 5;
	localparam int TICK_W      = 16;
	localparam int US_W        = 17;
	localparam int BYTE_W      = 8;
	localparam int BCNT_W      = 4;
	localparam int CNT_W       = 10;
	localparam int IB_W        = 3;

	localparam logic [US_W-1:0]   CAP_US    = 17'd120000;
	localparam logic [BCNT_W-1:0] BYTE_BITS = 4'd8;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SHIFT = 4'b0010,
		ST_READ  = 4'b0100,
		ST_REJ   = 4'b1000
	} state_t;

	typedef struct packed {
		logic load_entry;
		logic open_rec;
		logic take_byte;
		logic shift;
		logic emit_pair;
		logic emit_rej;
	} ctl_cmd_t;

	typedef struct packed {
		logic more_bits;
		logic idx_done;
		logic too_many;
	} dp_stat_t;

endpackage

// File: src/itpd_ifs.sv
// Valid/ready channel interfaces for the input beats and the result beats.
interface itpd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [4:0]  table_index;
	logic [15:0] on_ticks;
	logic [15:0] off_ticks;
	logic [2:0]  index_bits;
	logic [9:0]  pair_count;
	logic [7:0]  code_byte;

	modport source (output valid, kind, table_index, on_ticks, off_ticks, index_bits,
		pair_count, code_byte, input ready);
	modport sink (input valid, kind, table_index, on_ticks, off_ticks, index_bits,
		pair_count, code_byte, output ready);
endinterface

interface itpd_out_if;
	logic        valid;
	logic        ready;
	logic [16:0] on_us;
	logic [16:0] off_us;
	logic        last_pair;
	logic        rejected;

	modport source (output valid, on_us, off_us, last_pair, rejected, input ready);
	modport sink (input valid, on_us, off_us, last_pair, rejected, output ready);
endinterface

// File: src/itpd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module itpd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/itpd_ctrl.sv
// Controller state machine: sequences accept, bit shifting, lookup and result load.
module itpd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          kind,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  itpd_pkg::dp_stat_t  stat,
	output itpd_pkg::ctl_cmd_t  cmd
);

	itpd_pkg::state_t state_q, state_nx;
	logic out_valid_q;
	logic slot_free;
	logic accept;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == itpd_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			itpd_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						itpd_pkg::KIND_LOAD: begin
							cmd.load_entry = 1'b1;
						end
						itpd_pkg::KIND_START: begin
							cmd.open_rec = 1'b1;
							if (stat.too_many) begin
								state_nx = itpd_pkg::ST_REJ;
							end
						end
						itpd_pkg::KIND_BYTE: begin
							cmd.take_byte = 1'b1;
							state_nx      = itpd_pkg::ST_SHIFT;
						end
						default: begin
						end
					endcase
				end
			end
			itpd_pkg::ST_SHIFT: begin
				if (!stat.more_bits) begin
					state_nx = itpd_pkg::ST_IDLE;
				end else begin
					cmd.shift = 1'b1;
					if (stat.idx_done) begin
						state_nx = itpd_pkg::ST_READ;
					end
				end
			end
			itpd_pkg::ST_READ: begin
				if (slot_free) begin
					cmd.emit_pair = 1'b1;
					state_nx      = itpd_pkg::ST_SHIFT;
				end
			end
			itpd_pkg::ST_REJ: begin
				if (slot_free) begin
					cmd.emit_rej = 1'b1;
					state_nx     = itpd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = itpd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itpd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.emit_pair || cmd.emit_rej) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/itpd_dp.sv
// Datapath: timing table, bit unpacker, record counters and result register.
module itpd_dp #(
	parameter int INDEX_BITS_MAX = 5,
	parameter int MAX_PAIRS      = 600
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [4:0]          table_index,
	input  logic [15:0]         on_ticks,
	input  logic [15:0]         off_ticks,
	input  logic [2:0]          index_bits,
	input  logic [9:0]          pair_count,
	input  logic [7:0]          code_byte,
	input  itpd_pkg::ctl_cmd_t  cmd,
	output itpd_pkg::dp_stat_t  stat,
	output logic [16:0]         on_us,
	output logic [16:0]         off_us,
	output logic                last_pair,
	output logic                rejected
);

	localparam int IDX_W = INDEX_BITS_MAX;
	localparam int RAM_W = 2 * itpd_pkg::TICK_W;

	logic [itpd_pkg::IB_W-1:0]   width_q;
	logic [itpd_pkg::CNT_W-1:0]  pairs_q;
	logic [IDX_W-1:0]            part_q;
	logic [itpd_pkg::IB_W-1:0]   pbits_q;
	logic [itpd_pkg::BYTE_W-1:0] byte_q;
	logic [itpd_pkg::BCNT_W-1:0] bcnt_q;
	logic                        last_q;

	logic [itpd_pkg::US_W-1:0]   on_q, off_q;
	logic                        last_out_q, rej_q;

	logic [IDX_W-1:0]                   part_nx;
	logic [IDX_W+itpd_pkg::TABLE_AW-1:0] part_ext;
	logic [itpd_pkg::TABLE_AW-1:0]      raddr;
	logic [itpd_pkg::IB_W:0]            ib_ext;
	logic [itpd_pkg::IB_W-1:0]          width_nx;
	logic [RAM_W-1:0]                   rdata;
	logic                               ram_re;

	function automatic logic [itpd_pkg::US_W-1:0] scale_cap(
		input logic [itpd_pkg::TICK_W-1:0] t
	);
		logic [itpd_pkg::TICK_W+3:0] us;
		us = {1'b0, t, 3'b000} + {3'b000, t, 1'b0};
		if (us > 20'(itpd_pkg::CAP_US)) begin
			return itpd_pkg::CAP_US;
		end
		return us[itpd_pkg::US_W-1:0];
	endfunction

	// next partial index with the current MSB of the byte shifted in
	assign part_nx  = IDX_W'({part_q, byte_q[itpd_pkg::BYTE_W-1]});
	assign part_ext = {{itpd_pkg::TABLE_AW{1'b0}}, part_nx};
	assign raddr    = part_ext[itpd_pkg::TABLE_AW-1:0];
	assign ram_re   = cmd.shift && stat.idx_done;

	// index width: zero taken as one, saturated at the configured maximum
	assign ib_ext = {1'b0, index_bits};
	always_comb begin
		priority if (index_bits == '0) begin
			width_nx = itpd_pkg::IB_W'(1);
		end else if (ib_ext > (itpd_pkg::IB_W+1)'(INDEX_BITS_MAX)) begin
			width_nx = itpd_pkg::IB_W'(INDEX_BITS_MAX);
		end else begin
			width_nx = index_bits;
		end
	end

	assign stat.too_many  = pair_count > itpd_pkg::CNT_W'(MAX_PAIRS);
	assign stat.more_bits = (pairs_q != '0) && (bcnt_q != '0);
	assign stat.idx_done  = ({1'b0, pbits_q} + 4'd1) >= {1'b0, width_q};

	itpd_ram #(
		.WIDTH (RAM_W),
		.DEPTH (itpd_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.load_entry),
		.waddr (table_index),
		.wdata ({on_ticks, off_ticks}),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= itpd_pkg::IB_W'(1);
			pairs_q <= '0;
			part_q  <= '0;
			pbits_q <= '0;
			bcnt_q  <= '0;
		end else begin
			if (cmd.open_rec) begin
				part_q  <= '0;
				pbits_q <= '0;
				if (stat.too_many) begin
					pairs_q <= '0;
				end else begin
					pairs_q <= pair_count;
					width_q <= width_nx;
				end
			end
			if (cmd.take_byte) begin
				bcnt_q <= itpd_pkg::BYTE_BITS;
			end
			if (cmd.shift) begin
				bcnt_q <= bcnt_q - 1'b1;
				if (stat.idx_done) begin
					pairs_q <= pairs_q - 1'b1;
					part_q  <= '0;
					pbits_q <= '0;
				end else begin
					part_q  <= part_nx;
					pbits_q <= pbits_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			byte_q <= code_byte;
		end else if (cmd.shift) begin
			byte_q <= {byte_q[itpd_pkg::BYTE_W-2:0], 1'b0};
		end
		if (ram_re) begin
			last_q <= (pairs_q == itpd_pkg::CNT_W'(1));
		end
		if (cmd.emit_pair) begin
			on_q       <= scale_cap(rdata[RAM_W-1:itpd_pkg::TICK_W]);
			off_q      <= scale_cap(rdata[itpd_pkg::TICK_W-1:0]);
			last_out_q <= last_q;
			rej_q      <= 1'b0;
		end else if (cmd.emit_rej) begin
			on_q       <= '0;
			off_q      <= '0;
			last_out_q <= 1'b0;
			rej_q      <= 1'b1;
		end
	end

	assign on_us     = on_q;
	assign off_us    = off_q;
	assign last_pair = last_out_q;
	assign rejected  = rej_q;

endmodule

// File: src/ir_timing_pair_decoder_core.sv
// Top level of the IR timing pair decoder: controller, datapath and channel wiring.
//
// Expands packed IR code records into mark/space pairs. A load beat writes one of
// 32 timing table entries; a start beat opens a record (index width, pair count)
// or, when the count exceeds MAX_PAIRS, yields one beat with rejected set; a code
// byte beat is unpacked MSB first, and each complete index looks up the table and
// yields a pair scaled to microseconds (x10, capped at 120000), the final pair of
// the record carrying last_pair. A rejected start passes through the reject state,
// and a code byte is walked one bit per cycle until its bits or the record's pairs
// run out, with a read state after each complete index for the registered read of
// the timing table RAM, where the walk waits while the result register is occupied.
// The result register lets a new beat be accepted while the previous result
// waits; the controller only stalls when the next result is ready and the
// register is still occupied. Table entries never loaded read back as undefined.
module ir_timing_pair_decoder_core #(
	parameter int INDEX_BITS_MAX = 5,
	parameter int MAX_PAIRS      = 600
) (
	input logic         clk,
	input logic         arst_n,
	itpd_in_if.sink     in_ch,
	itpd_out_if.source  out_ch
);

	itpd_pkg::ctl_cmd_t cmd;
	itpd_pkg::dp_stat_t stat;

	// sequencing: accept, per-bit walk, lookup wait, result hand-off
	itpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.kind      (in_ch.kind),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// table, unpacker, record counters and the result register
	itpd_dp #(
		.INDEX_BITS_MAX (INDEX_BITS_MAX),
		.MAX_PAIRS      (MAX_PAIRS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.table_index (in_ch.table_index),
		.on_ticks    (in_ch.on_ticks),
		.off_ticks   (in_ch.off_ticks),
		.index_bits  (in_ch.index_bits),
		.pair_count  (in_ch.pair_count),
		.code_byte   (in_ch.code_byte),
		.cmd         (cmd),
		.stat        (stat),
		.on_us       (out_ch.on_us),
		.off_us      (out_ch.off_us),
		.last_pair   (out_ch.last_pair),
		.rejected    (out_ch.rejected)
	);

endmodule

// File: src/itpd_checker.sv
// Port-level assertions for the IR timing pair decoder, bound to the top level.
module itpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] on_us,
	input logic [16:0] off_us,
	input logic        last_pair,
	input logic        rejected
);

	// a rejected start carries no durations and no last flag
	a_rej_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> on_us == '0 && off_us == '0 && !last_pair)
	else $error("rejected beat carries nonzero payload");

	// durations never exceed the cap
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> on_us <= itpd_pkg::CAP_US && off_us <= itpd_pkg::CAP_US)
	else $error("duration above cap");

	// a code byte keeps the input side busy while it is unpacked
	a_byte_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == itpd_pkg::KIND_BYTE |=> !in_ready)
	else $error("input taken right after a code byte");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(on_us) && $stable(off_us)
			&& $stable(last_pair) && $stable(rejected))
	else $error("stalled result changed");

endmodule

bind ir_timing_pair_decoder_core itpd_checker u_itpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.kind      (in_ch.kind),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.on_us     (out_ch.on_us),
	.off_us    (out_ch.off_us),
	.last_pair (out_ch.last_pair),
	.rejected  (out_ch.rejected)
);

// File: tb/testbench.sv
// Self-checking testbench for ir_timing_pair_decoder_core: directed table, then random records.
module testbench;
	import itpd_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int IDX_W_MAX     = 5;
	localparam int PAIR_LIMIT    = 600;
	localparam int US_PER_TICK   = 10;
	localparam int DIRECTED_ROWS = 26;
	localparam int TOTAL_BEATS   = 450;
	localparam int CALM_TAIL     = 60;
	localparam int LONG_HOLD     = 400;
	localparam int HOLD_AFTER    = 60;
	localparam int DRAIN_CYCLES  = 40;
	localparam int RUN_LIMIT     = 5_000_000;

	typedef struct packed {
		logic [1:0]          kind;
		logic [TABLE_AW-1:0] tidx;
		logic [TICK_W-1:0]   on_t;
		logic [TICK_W-1:0]   off_t;
		logic [IB_W-1:0]     ib;
		logic [CNT_W-1:0]    pc;
		logic [BYTE_W-1:0]   cb;
	} in_beat_t;

	typedef struct packed {
		logic [US_W-1:0] on_us;
		logic [US_W-1:0] off_us;
		logic            last_pair;
		logic            rejected;
	} pair_beat_t;

	// typed: expectation given in the row (n pairs, all alike, last flag on the final one)
	typedef struct {
		in_beat_t        beat;
		bit              typed;
		int              n;
		logic [US_W-1:0] on_us;
		logic [US_W-1:0] off_us;
		bit              last_pair;
		bit              rejected;
	} dir_row_t;

	logic clk;
	logic arst_n;

	itpd_in_if  in_ch ();
	itpd_out_if out_ch ();

	ir_timing_pair_decoder_core #(
		.INDEX_BITS_MAX(IDX_W_MAX),
		.MAX_PAIRS(PAIR_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// decoder mirror
	logic [TICK_W-1:0] mark_tbl [TABLE_DEPTH];
	logic [TICK_W-1:0] space_tbl [TABLE_DEPTH];
	logic [7:0]        part_idx   = '0;
	int                part_bits  = 0;
	int                width_cur  = 1;
	int                pairs_left = 0;

	pair_beat_t expected_pairs [$];
	pair_beat_t fresh_pairs [$];

	int mismatches    = 0;
	int pairs_checked = 0;
	int beats_sent    = 0;
	bit gaps_on       = 1'b1;
	bit calm          = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [US_W-1:0] to_us(input logic [TICK_W-1:0] ticks);
		int unsigned scaled;
		scaled = 32'(ticks) * 32'(US_PER_TICK);
		return (scaled > 32'(CAP_US)) ? CAP_US : scaled[US_W-1:0];
	endfunction

	// mark/space pairs that one beat yields; updates the mirror state
	task automatic expand_beat(input in_beat_t b);
		int         bit_pos;
		pair_beat_t p;
		fresh_pairs.delete();
		case (b.kind)
			KIND_LOAD: begin
				mark_tbl[b.tidx]  = b.on_t;
				space_tbl[b.tidx] = b.off_t;
			end
			KIND_START: begin
				part_idx   = '0;
				part_bits  = 0;
				pairs_left = 0;
				if (int'(b.pc) > PAIR_LIMIT) begin
					p = '{on_us: '0, off_us: '0, last_pair: 1'b0, rejected: 1'b1};
					fresh_pairs.push_back(p);
				end else begin
					width_cur  = (b.ib == 0) ? 1 :
						((int'(b.ib) > IDX_W_MAX) ? IDX_W_MAX : int'(b.ib));
					pairs_left = int'(b.pc);
				end
			end
			KIND_BYTE: begin
				for (bit_pos = BYTE_W - 1; bit_pos >= 0 && pairs_left > 0; bit_pos--) begin
					part_idx = {part_idx[6:0], b.cb[bit_pos]};
					part_bits++;
					if (part_bits >= width_cur) begin
						pairs_left--;
						p.on_us     = to_us(mark_tbl[part_idx[TABLE_AW-1:0]]);
						p.off_us    = to_us(space_tbl[part_idx[TABLE_AW-1:0]]);
						p.last_pair = (pairs_left == 0);
						p.rejected  = 1'b0;
						fresh_pairs.push_back(p);
						part_idx  = '0;
						part_bits = 0;
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic in_beat_t rand_beat();
		in_beat_t b;
		b.kind  = 2'($urandom_range(0, 3));
		b.tidx  = TABLE_AW'($urandom_range(0, TABLE_DEPTH - 1));
		b.on_t  = TICK_W'($urandom_range(0, 65535));
		b.off_t = TICK_W'($urandom_range(0, 65535));
		b.ib    = IB_W'($urandom_range(0, 7));
		b.pc    = CNT_W'($urandom_range(0, 1023));
		b.cb    = BYTE_W'($urandom_range(0, 255));
		return b;
	endfunction

	// tick values leaning on zero, full scale and the cap boundary
	function automatic logic [TICK_W-1:0] pick_ticks();
		int sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0:       return '0;
			1:       return '1;
			2:       return TICK_W'($urandom_range(11990, 12010));
			default: return TICK_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic offer_beat(input dir_row_t r);
		int         k;
		pair_beat_t p;
		if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.kind        <= r.beat.kind;
		in_ch.table_index <= r.beat.tidx;
		in_ch.on_ticks    <= r.beat.on_t;
		in_ch.off_ticks   <= r.beat.off_t;
		in_ch.index_bits  <= r.beat.ib;
		in_ch.pair_count  <= r.beat.pc;
		in_ch.code_byte   <= r.beat.cb;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		expand_beat(r.beat);
		if (r.typed) begin
			for (k = 0; k < r.n; k++) begin
				p = '{on_us: r.on_us, off_us: r.off_us,
					last_pair: r.last_pair && (k == r.n - 1), rejected: r.rejected};
				expected_pairs.push_back(p);
			end
		end else begin
			foreach (fresh_pairs[k]) expected_pairs.push_back(fresh_pairs[k]);
		end
		beats_sent++;
		calm = (beats_sent >= TOTAL_BEATS - CALM_TAIL);
	endtask

	// result side: random back-pressure, one long hold-off, and the checks
	initial begin : result_side
		pair_beat_t got;
		pair_beat_t want;
		int         hold;
		bit         long_done;
		hold      = 0;
		long_done = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got = '{on_us: out_ch.on_us, off_us: out_ch.off_us,
					last_pair: out_ch.last_pair, rejected: out_ch.rejected};
				if (expected_pairs.size() == 0) begin
					$display("%0t: expected no beat, got on_us %0d off_us %0d last %0b rej %0b",
						$time, got.on_us, got.off_us, got.last_pair, got.rejected);
					mismatches++;
				end else begin
					want = expected_pairs.pop_front();
					pairs_checked++;
					if (got.on_us !== want.on_us) begin
						$display("%0t: on_us expected %0d, got %0d", $time, want.on_us, got.on_us);
						mismatches++;
					end
					if (got.off_us !== want.off_us) begin
						$display("%0t: off_us expected %0d, got %0d", $time, want.off_us,
							got.off_us);
						mismatches++;
					end
					if (got.last_pair !== want.last_pair) begin
						$display("%0t: last_pair expected %0b, got %0b", $time, want.last_pair,
							got.last_pair);
						mismatches++;
					end
					if (got.rejected !== want.rejected) begin
						$display("%0t: rejected expected %0b, got %0b", $time, want.rejected,
							got.rejected);
						mismatches++;
					end
				end
			end
			// the long hold-off lets the sender fill the block until it stalls its input
			if (!long_done && pairs_checked >= HOLD_AFTER) begin
				long_done = 1'b1;
				hold      = LONG_HOLD;
			end else if (hold == 0 && gaps_on && !calm && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 17);
			end
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		dir_row_t plan [DIRECTED_ROWS];
		dir_row_t r;
		int       i;
		int       k;
		int       sel;
		int       wide;
		int       nbytes;
		arst_n            <= 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.kind        <= KIND_LOAD;
		in_ch.table_index <= '0;
		in_ch.on_ticks    <= '0;
		in_ch.off_ticks   <= '0;
		in_ch.index_bits  <= '0;
		in_ch.pair_count  <= '0;
		in_ch.code_byte   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// beat: kind, entry, on, off, index bits, count, byte; then typed, n, on_us, off_us, last, rej
		plan = '{
			// code byte right after reset, no record open
			'{'{KIND_BYTE, 0, 0, 0, 0, 0, 8'hFF}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_LOAD, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_LOAD, 31, 16'hFFFF, 16'hFFFF, 0, 0, 0}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_LOAD, 1, 11999, 12000, 0, 0, 0}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_LOAD, 2, 56, 1690, 0, 0, 0}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_LOAD, 3, 1, 65534, 0, 0, 0}, 1, 0, 0, 0, 0, 0},
			// empty record, then a byte that nothing consumes
			'{'{KIND_START, 0, 0, 0, 1, 0, 0}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_BYTE, 0, 0, 0, 0, 0, 8'hAA}, 1, 0, 0, 0, 0, 0},
			// oversized counts: one reject beat each, nothing left open
			'{'{KIND_START, 0, 0, 0, 1, 601, 0}, 1, 1, 0, 0, 0, 1},
			'{'{KIND_BYTE, 0, 0, 0, 0, 0, 8'h00}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_START, 0, 0, 0, 7, 1023, 0}, 1, 1, 0, 0, 0, 1},
			// width 0 runs as 1; trailing bits ignored
			'{'{KIND_START, 0, 0, 0, 0, 3, 0}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_BYTE, 0, 0, 0, 0, 0, 8'hA0}, 0, 0, 0, 0, 0, 0},
			// width 7 saturates to 5; second index straddles the byte boundary
			'{'{KIND_START, 0, 0, 0, 7, 2, 0}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_BYTE, 0, 0, 0, 0, 0, 8'hF8}, 1, 1, CAP_US, CAP_US, 0, 0},
			'{'{KIND_BYTE, 0, 0, 0, 0, 0, 8'h02}, 1, 1, 0, 0, 1, 0},
			// largest accepted count
			'{'{KIND_START, 0, 0, 0, 2, 600, 0}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_BYTE, 0, 0, 0, 0, 0, 8'h1B}, 0, 0, 0, 0, 0, 0},
			// restart mid record, with partial bits pending
			'{'{KIND_START, 0, 0, 0, 3, 5, 0}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_BYTE, 0, 0, 0, 0, 0, 8'h05}, 0, 0, 0, 0, 0, 0},
			'{'{KIND_START, 0, 0, 0, 4, 1, 0}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_BYTE, 0, 0, 0, 0, 0, 8'h30}, 0, 0, 0, 0, 0, 0},
			'{'{KIND_UNUSED, 31, 16'hFFFF, 16'hFFFF, 7, 1023, 8'hFF}, 1, 0, 0, 0, 0, 0},
			// eight pairs from one byte
			'{'{KIND_START, 0, 0, 0, 1, 9, 0}, 1, 0, 0, 0, 0, 0},
			'{'{KIND_BYTE, 0, 0, 0, 0, 0, 8'h55}, 0, 0, 0, 0, 0, 0},
			'{'{KIND_BYTE, 0, 0, 0, 0, 0, 8'h80}, 0, 0, 0, 0, 0, 0}
		};
		foreach (plan[i]) offer_beat(plan[i]);

		r = plan[0];
		r.typed = 1'b0;

		// fill the whole table so any index a record can form has been written
		for (i = 0; i < TABLE_DEPTH; i++) begin
			r.beat       = rand_beat();
			r.beat.kind  = KIND_LOAD;
			r.beat.tidx  = TABLE_AW'(i);
			r.beat.on_t  = pick_ticks();
			r.beat.off_t = pick_ticks();
			offer_beat(r);
		end

		while (beats_sent < TOTAL_BEATS) begin
			if ($urandom_range(0, 5) == 0) gaps_on = !gaps_on;
			sel = $urandom_range(0, 19);
			if (sel < 15) begin
				// a well-formed record with random content
				r.beat      = rand_beat();
				r.beat.kind = KIND_START;
				k           = $urandom_range(0, 9);
				if (k < 7)
					r.beat.pc = CNT_W'($urandom_range(1, 16));
				else if (k < 9)
					r.beat.pc = CNT_W'($urandom_range(17, PAIR_LIMIT));
				else
					r.beat.pc = CNT_W'(PAIR_LIMIT);
				wide = (r.beat.ib == 0) ? 1 :
					((int'(r.beat.ib) > IDX_W_MAX) ? IDX_W_MAX : int'(r.beat.ib));
				offer_beat(r);
				nbytes = (int'(r.beat.pc) * wide + BYTE_W - 1) / BYTE_W;
				if (nbytes > 30)
					nbytes = $urandom_range(4, 30);
				else if ($urandom_range(0, 7) == 0)
					nbytes = $urandom_range(0, nbytes);
				else if ($urandom_range(0, 4) == 0)
					nbytes++;
				for (k = 0; k < nbytes; k++) begin
					r.beat      = rand_beat();
					r.beat.kind = KIND_BYTE;
					offer_beat(r);
				end
			end else if (sel < 17) begin
				r.beat = rand_beat();
				offer_beat(r);
			end else if (sel == 17) begin
				r.beat      = rand_beat();
				r.beat.kind = KIND_START;
				r.beat.pc   = ($urandom_range(0, 1) == 0) ? '0 :
					CNT_W'($urandom_range(PAIR_LIMIT + 1, 1023));
				offer_beat(r);
			end else begin
				r.beat       = rand_beat();
				r.beat.kind  = KIND_LOAD;
				r.beat.on_t  = pick_ticks();
				r.beat.off_t = pick_ticks();
				offer_beat(r);
			end
		end

		in_ch.valid <= 1'b0;
		while (expected_pairs.size() != 0) @(posedge clk);
		// a byte may still be walking ignored bits after its last pair
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: ir_timing_pair_decoder_core.f
src/itpd_pkg.sv
src/itpd_ifs.sv
src/itpd_ram.sv
src/itpd_ctrl.sv
src/itpd_dp.sv
src/ir_timing_pair_decoder_core.sv
src/itpd_checker.sv
tb/testbench.sv
